### sv/bdc_pkg.sv
// Package for the detection head box decoder: payload structs, register
// indexes, item kinds, pipeline enable bundle and reset values.
// No dependencies.
package bdc_pkg;

  // Default sizes, handed to the top-level parameters
  localparam int MAX_CLASSES_DEF    = 256;
  localparam int MAX_IMAGE_SIDE_DEF = 8192;

  // Configuration port sizing
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;

  // Register reset values
  localparam logic [15:0] SCORE_THRESHOLD_RST = 16'd16384;
  localparam logic [23:0] INVERSE_GAIN_RST    = 24'd65536;
  localparam logic [14:0] PAD_RST             = 15'd0;
  localparam logic [13:0] IMAGE_SIDE_RST      = 14'd640;
  localparam logic [8:0]  CLASS_COUNT_RST     = 9'd80;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_THRESHOLD = 3'd0,
    REG_INVERSE_GAIN    = 3'd1,
    REG_PAD_X           = 3'd2,
    REG_PAD_Y           = 3'd3,
    REG_IMAGE_WIDTH     = 3'd4,
    REG_IMAGE_HEIGHT    = 3'd5,
    REG_CLASS_COUNT     = 3'd6
  } cfg_reg_t;

  // Item kinds
  localparam logic KIND_COORD = 1'b0;
  localparam logic KIND_SCORE = 1'b1;

  // Input beat
  typedef struct packed {
    logic               kind;
    logic signed [15:0] centre_x;
    logic signed [15:0] centre_y;
    logic signed [15:0] box_width;
    logic signed [15:0] box_height;
    logic [15:0]        score;
    logic               last_score;
  } cand_t;

  // Output beat
  typedef struct packed {
    logic [7:0]  class_id;
    logic [15:0] confidence;
    logic [12:0] left;
    logic [12:0] top;
    logic [13:0] width;
    logic [13:0] height;
  } det_t;

  // Closed candidate handed from the score tracker to the box pipeline
  typedef struct packed {
    logic [15:0]        conf;
    logic [7:0]         cls;
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] w;
    logic signed [15:0] h;
  } snap_t;

  // Load enables of the box mapping stages
  typedef struct packed {
    logic prod;
    logic clamp;
    logic out;
  } stage_en_t;

endpackage

### sv/bdc_score_track.sv
// Score tracker: holds box coordinates, keeps the running first maximum over
// class scores and registers a snapshot of each candidate that passes.
// Depends on bdc_pkg.
module bdc_score_track #(
  parameter int MAX_CLASSES = bdc_pkg::MAX_CLASSES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  bdc_pkg::cand_t cand,
  input  logic [15:0]   score_threshold,
  input  logic [8:0]    class_count,
  output logic          close,
  output bdc_pkg::snap_t snap
);
  import bdc_pkg::*;

  localparam int SEEN_W = $clog2(MAX_CLASSES + 1);

  logic signed [15:0] held_centre_x;
  logic signed [15:0] held_centre_y;
  logic signed [15:0] held_width;
  logic signed [15:0] held_height;
  logic [15:0]        best_score;
  logic [7:0]         best_class;
  logic [SEEN_W-1:0]  seen;

  logic [SEEN_W-1:0]  cnt;
  logic               take;
  logic               better;
  logic [15:0]        best_score_next;
  logic [7:0]         best_class_next;

  // Limit the class count to 1..MAX_CLASSES
  always_comb begin
    if (class_count == 9'd0) begin
      cnt = SEEN_W'(1);
    end else if ({23'd0, class_count} > 32'(MAX_CLASSES)) begin
      cnt = SEEN_W'(MAX_CLASSES);
    end else begin
      cnt = SEEN_W'(class_count);
    end
  end

  // Running first maximum including the score on the input
  always_comb begin
    take            = seen < cnt;
    better          = take && ((seen == '0) || (cand.score > best_score));
    best_score_next = better ? cand.score : best_score;
    best_class_next = better ? 8'(seen) : best_class;
  end

  assign close = accept && (cand.kind == KIND_SCORE) && cand.last_score &&
                 (best_score_next > score_threshold);

  // Update held coordinates and the running maximum
  always_ff @(posedge clk) begin
    if (rst) begin
      held_centre_x <= '0;
      held_centre_y <= '0;
      held_width    <= '0;
      held_height   <= '0;
      best_score    <= '0;
      best_class    <= '0;
      seen          <= '0;
    end else if (accept) begin
      if (cand.kind == KIND_COORD) begin
        held_centre_x <= cand.centre_x;
        held_centre_y <= cand.centre_y;
        held_width    <= cand.box_width;
        held_height   <= cand.box_height;
        best_score    <= '0;
        best_class    <= '0;
        seen          <= '0;
      end else if (cand.last_score) begin
        best_score <= '0;
        best_class <= '0;
        seen       <= '0;
      end else begin
        best_score <= best_score_next;
        best_class <= best_class_next;
        if (take) begin
          seen <= seen + 1'b1;
        end
      end
    end
  end

  // Capture the closing candidate
  always_ff @(posedge clk) begin
    if (close) begin
      snap.conf <= best_score_next;
      snap.cls  <= best_class_next;
      snap.cx   <= held_centre_x;
      snap.cy   <= held_centre_y;
      snap.w    <= held_width;
      snap.h    <= held_height;
    end
  end

`ifndef NO_ASSERTIONS
  a_coord_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && (cand.kind == KIND_COORD)) |=> (seen == '0) && (best_score == '0))
    else $error("coordinate beat did not clear the running maximum");

  a_seen_counts: assert property (@(posedge clk) disable iff (rst)
    (accept && (cand.kind == KIND_SCORE) && !cand.last_score && (seen < cnt))
    |=> (seen == $past(seen) + 1'b1))
    else $error("score counter did not advance");
`endif

endmodule

### sv/bdc_axis_map.sv
// One axis of the letterbox-to-image mapping: padding, gain products, corner
// truncation and clamp, size limit. Three registered stages.
// Depends on bdc_pkg.
module bdc_axis_map #(
  parameter int MAX_IMAGE_SIDE = bdc_pkg::MAX_IMAGE_SIDE_DEF
) (
  input  logic               clk,
  input  bdc_pkg::stage_en_t en,
  input  logic signed [15:0] centre,
  input  logic signed [15:0] size,
  input  logic [14:0]        pad,
  input  logic [13:0]        side,
  input  logic [23:0]        gain,
  output logic [12:0]        edge_px,
  output logic [13:0]        size_px,
  output logic               ok
);
  import bdc_pkg::*;

  logic signed [17:0] diff;
  logic signed [42:0] c_prod;
  logic signed [40:0] w_prod;

  logic [13:0]        lim;
  logic [13:0]        lim_m1;
  logic signed [44:0] n;
  logic [23:0]        q;
  logic [13:0]        edge_next;
  logic [13:0]        edge_b;
  logic [13:0]        lim_b;
  logic signed [40:0] w_b;

  logic [13:0]        span;
  logic [33:0]        room;
  logic               w_pos;
  logic               w_over;
  logic               ok_next;
  logic [13:0]        size_next;

  // Subtract padding from the centre (Q11.4, sign-extended)
  assign diff = {{2{centre[15]}}, centre} - {3'b000, pad};

  // Multiply by the inverse gain, Q.20 results
  always_ff @(posedge clk) begin
    if (en.prod) begin
      c_prod <= diff * $signed({1'b0, gain});
      w_prod <= size * $signed({1'b0, gain});
    end
  end

  // Limit the image side to 1..MAX_IMAGE_SIDE
  always_comb begin
    if (side == 14'd0) begin
      lim = 14'd1;
    end else if ({18'd0, side} > 32'(MAX_IMAGE_SIDE)) begin
      lim = 14'(MAX_IMAGE_SIDE);
    end else begin
      lim = side;
    end
    lim_m1 = lim - 14'd1;
  end

  // Corner in Q.21: 2c - w, truncate toward zero, clamp into the image
  always_comb begin
    n = {c_prod[42], c_prod, 1'b0} - {{4{w_prod[40]}}, w_prod};
    q = n[44:21];
    if (n[44]) begin
      edge_next = '0;
    end else if (q > {10'd0, lim_m1}) begin
      edge_next = lim_m1;
    end else begin
      edge_next = q[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.clamp) begin
      edge_b <= edge_next;
      lim_b  <= lim;
      w_b    <= w_prod;
    end
  end

  // Limit the size to the room left in the image, keep positive sizes only
  always_comb begin
    span      = lim_b - edge_b;
    room      = {span, 20'd0};
    w_pos     = !w_b[40];
    w_over    = w_pos && (w_b[39:0] > {6'd0, room});
    ok_next   = w_over || (w_pos && (w_b != '0));
    size_next = w_over ? span : w_b[33:20];
  end

  always_ff @(posedge clk) begin
    if (en.out) begin
      edge_px <= edge_b[12:0];
      size_px <= size_next;
      ok      <= ok_next;
    end
  end

endmodule

### sv/detection_head_box_decode_core.sv
// Detection head box decoder, top level: configuration registers, pipeline
// control and output register. Uses bdc_score_track and bdc_axis_map.
// Depends on bdc_pkg.
//
// Takes one beat per clock unless cand_stall is high: a coordinate beat
// latches a box, score beats update the running first maximum in the same
// cycle. A last score whose best score is strictly above score_threshold
// starts a four-stage box pipeline (snapshot, gain products, corner clamp,
// size limit into the output register); det_valid rises once the closing
// beat has passed all four registers and the box has positive size on both
// axes. Each passing last score gives at most one detection.
// The maximum update sets the input rate of one beat per clock;
// a stalled output only holds back input once every pipeline stage is full.
// Configuration may be written only while no box is in flight. No clearing
// pass after reset.
module detection_head_box_decode_core #(
  parameter int MAX_CLASSES    = bdc_pkg::MAX_CLASSES_DEF,
  parameter int MAX_IMAGE_SIDE = bdc_pkg::MAX_IMAGE_SIDE_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cand_valid,
  output logic                           cand_stall,
  input  bdc_pkg::cand_t                 cand,
  output logic                           det_valid,
  input  logic                           det_stall,
  output bdc_pkg::det_t                  det,
  input  logic                           cfg_write,
  input  logic [bdc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bdc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bdc_pkg::*;

  logic [15:0] score_threshold;
  logic [23:0] inverse_gain;
  logic [14:0] pad_x;
  logic [14:0] pad_y;
  logic [13:0] image_width;
  logic [13:0] image_height;
  logic [8:0]  class_count;

  logic        accept;
  logic        close;
  snap_t       snap;

  logic        v1;
  logic        v2;
  logic        v3;
  logic        vout;
  logic        rdy1;
  logic        rdy2;
  logic        rdy3;
  logic        rdy_out;
  stage_en_t   en;

  logic [15:0] conf2;
  logic [15:0] conf3;
  logic [15:0] conf_out;
  logic [7:0]  cls2;
  logic [7:0]  cls3;
  logic [7:0]  cls_out;

  logic [12:0] left_px;
  logic [12:0] top_px;
  logic [13:0] width_px;
  logic [13:0] height_px;
  logic        ok_x;
  logic        ok_y;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= SCORE_THRESHOLD_RST;
      inverse_gain    <= INVERSE_GAIN_RST;
      pad_x           <= PAD_RST;
      pad_y           <= PAD_RST;
      image_width     <= IMAGE_SIDE_RST;
      image_height    <= IMAGE_SIDE_RST;
      class_count     <= CLASS_COUNT_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCORE_THRESHOLD: score_threshold <= cfg_data[15:0];
        REG_INVERSE_GAIN:    inverse_gain    <= cfg_data[23:0];
        REG_PAD_X:           pad_x           <= cfg_data[14:0];
        REG_PAD_Y:           pad_y           <= cfg_data[14:0];
        REG_IMAGE_WIDTH:     image_width     <= cfg_data[13:0];
        REG_IMAGE_HEIGHT:    image_height    <= cfg_data[13:0];
        REG_CLASS_COUNT:     class_count     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Stage readiness: a stage loads when empty or when its successor moves
  always_comb begin
    det_valid  = vout && ok_x && ok_y;
    rdy_out    = !det_valid || !det_stall;
    rdy3       = !v3 || rdy_out;
    rdy2       = !v2 || rdy3;
    rdy1       = !v1 || rdy2;
    cand_stall = !rdy1;
    accept     = cand_valid && rdy1;
    en.prod    = rdy2;
    en.clamp   = rdy3;
    en.out     = rdy_out;
  end

  bdc_score_track #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_score (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .cand           (cand),
    .score_threshold(score_threshold),
    .class_count    (class_count),
    .close          (close),
    .snap           (snap)
  );

  // Advance the stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (rdy1) begin
        v1 <= close;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (rdy_out) begin
        vout <= v3;
      end
    end
  end

  // Carry class and confidence alongside the box stages
  always_ff @(posedge clk) begin
    if (en.prod) begin
      conf2 <= snap.conf;
      cls2  <= snap.cls;
    end
    if (en.clamp) begin
      conf3 <= conf2;
      cls3  <= cls2;
    end
    if (en.out) begin
      conf_out <= conf3;
      cls_out  <= cls3;
    end
  end

  bdc_axis_map #(
    .MAX_IMAGE_SIDE(MAX_IMAGE_SIDE)
  ) u_axis_x (
    .clk    (clk),
    .en     (en),
    .centre (snap.cx),
    .size   (snap.w),
    .pad    (pad_x),
    .side   (image_width),
    .gain   (inverse_gain),
    .edge_px(left_px),
    .size_px(width_px),
    .ok     (ok_x)
  );

  bdc_axis_map #(
    .MAX_IMAGE_SIDE(MAX_IMAGE_SIDE)
  ) u_axis_y (
    .clk    (clk),
    .en     (en),
    .centre (snap.cy),
    .size   (snap.h),
    .pad    (pad_y),
    .side   (image_height),
    .gain   (inverse_gain),
    .edge_px(top_px),
    .size_px(height_px),
    .ok     (ok_y)
  );

  // Assemble the output beat
  always_comb begin
    det.class_id   = cls_out;
    det.confidence = conf_out;
    det.left       = left_px;
    det.top        = top_px;
    det.width      = width_px;
    det.height     = height_px;
  end

`ifndef NO_ASSERTIONS
  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !v1 |-> !cand_stall)
    else $error("input held back with the snapshot stage empty");

  a_conf_above: assert property (@(posedge clk) disable iff (rst)
    det_valid |-> (det.confidence > score_threshold))
    else $error("detection leaves with confidence at or below threshold");

  a_close_moves: assert property (@(posedge clk) disable iff (rst)
    close |=> v1)
    else $error("passing candidate not captured in the snapshot stage");
`endif

endmodule

### dv/tb_detection_head_box_decode_core.sv
// Testbench for detection_head_box_decode_core: directed table, then random
// boxes under several register settings, checked against an in-bench decoder.
// Depends on bdc_pkg and the core RTL.
module tb_detection_head_box_decode_core;
  import bdc_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cand_valid;
  logic                  cand_stall;
  cand_t                 cand;
  logic                  det_valid;
  logic                  det_stall;
  det_t                  det;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  detection_head_box_decode_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .cand_valid(cand_valid),
    .cand_stall(cand_stall),
    .cand      (cand),
    .det_valid (det_valid),
    .det_stall (det_stall),
    .det       (det),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // How a directed row is checked
  typedef enum {CHK_MODEL, CHK_NONE, CHK_DET} chk_t;

  typedef struct {
    logic kind;
    int   cx, cy, bw, bh;
    int   sc;
    bit   last;
    chk_t chk;
    int   e_cls, e_conf, e_left, e_top, e_w, e_h;
  } dir_row_t;

  typedef struct {
    int thr, gain, padx, pady, iw, ih, cls;
    bit quiet;
  } cfg_row_t;

  localparam int DIR_ROWS   = 21;
  localparam int FIXED_CFGS = 6;
  localparam int PHASES     = 13;
  localparam int PHASE_BEATS = 50;
  localparam int DRAIN_CYCLES = 8;

  // Rows run on reset register values: threshold 0x4000, unit gain, 640x640
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{KIND_SCORE, 0, 0, 0, 0, 'hFFFF, 1, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_COORD, 1600, 1600, 320, 320, 0, 0, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'h8000, 1, CHK_DET, 0, 'h8000, 90, 90, 20, 20},
    '{KIND_SCORE, 0, 0, 0, 0, 'h1000, 0, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'h9000, 0, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'h9000, 0, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'h4000, 1, CHK_DET, 1, 'h9000, 90, 90, 20, 20},
    '{KIND_SCORE, 0, 0, 0, 0, 'h4000, 1, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'h4001, 1, CHK_DET, 0, 'h4001, 90, 90, 20, 20},
    '{KIND_SCORE, 0, 0, 0, 0, 0, 1, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_COORD, 32767, -32768, 32767, 32767, 0, 0, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, -1, -1, -1, -1, 'hFFFF, 1, CHK_MODEL, 0, 0, 0, 0, 0, 0},
    '{KIND_COORD, 1600, 1600, -16, 320, 0, 0, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'hFFFF, 1, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_COORD, 1600, 1600, 8, 8, 0, 0, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'hC000, 1, CHK_MODEL, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'hF000, 0, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_COORD, -32768, 32767, -32768, 0, 'hFFFF, 1, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_COORD, 800, 960, 640, 480, 'h5555, 1, CHK_NONE, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'h5000, 1, CHK_MODEL, 0, 0, 0, 0, 0, 0},
    '{KIND_SCORE, 0, 0, 0, 0, 'hFFFF, 1, CHK_MODEL, 0, 0, 0, 0, 0, 0}
  };

  // Extreme and corner register settings; the rest of the phases are random
  cfg_row_t fixed_cfgs [FIXED_CFGS] = '{
    '{0, 65536, 0, 0, 640, 480, 1, 0},
    '{65535, 16777215, 32767, 32767, 8192, 8192, 256, 0},
    '{100, 0, 100, 200, 1, 1, 3, 1},
    '{16384, 32768, 16, 16, 0, 16383, 0, 0},
    '{8000, 131072, 640, 320, 1920, 1080, 511, 0},
    '{8192, 65536, 0, 0, 8192, 1, 256, 1}
  };

  // Decoder state and register copies
  logic [15:0]        thr_q;
  logic [23:0]        gain_q;
  logic [14:0]        pad_x_q, pad_y_q;
  logic [13:0]        img_w_q, img_h_q;
  logic [8:0]         class_q;
  logic signed [15:0] held_cx, held_cy, held_w, held_h;
  logic [15:0]        best_s;
  logic [7:0]         best_c;
  int                 seen;

  det_t pending_dets[$];
  int   mismatch_count = 0;
  bit   no_idle = 1'b0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Map one axis from letterbox space; returns 1 when the size is positive
  function automatic bit map_axis(input logic signed [15:0] ctr,
                                  input logic signed [15:0] sz,
                                  input logic [14:0] pad, input logic [13:0] side,
                                  output longint edge_px, output longint size_px);
    longint g, c, w, n, e, lim, room;
    g = longint'(gain_q);
    c = (longint'(ctr) - longint'(pad)) * g;
    w = longint'(sz) * g;
    n = 2 * c - w;
    if (n < 0) e = -((-n) >>> 21);
    else e = n >>> 21;
    lim = longint'(side);
    if (lim < 1) lim = 1;
    if (lim > MAX_IMAGE_SIDE_DEF) lim = MAX_IMAGE_SIDE_DEF;
    if (e > lim - 1) e = lim - 1;
    if (e < 0) e = 0;
    room = (lim - e) <<< 20;
    if (w > room) w = room;
    edge_px = e;
    if (w <= 0) begin
      size_px = 0;
      return 1'b0;
    end
    size_px = w >>> 20;
    return 1'b1;
  endfunction

  // Advance the decoder by one beat; returns 1 with the detection if one leaves
  function automatic bit decode_beat(input cand_t b, output det_t d);
    int          cnt;
    logic [15:0] conf;
    logic [7:0]  cls;
    longint      lx, ty, wx, hy;
    bit          ok_x, ok_y;
    d = '0;
    if (b.kind == KIND_COORD) begin
      held_cx = b.centre_x;
      held_cy = b.centre_y;
      held_w  = b.box_width;
      held_h  = b.box_height;
      best_s = '0;
      best_c = '0;
      seen = 0;
      return 1'b0;
    end
    cnt = int'(class_q);
    if (cnt < 1) cnt = 1;
    if (cnt > MAX_CLASSES_DEF) cnt = MAX_CLASSES_DEF;
    // first maximum wins; scores past the class count do not compete
    if (seen < cnt) begin
      if (seen == 0 || b.score > best_s) begin
        best_s = b.score;
        best_c = 8'(seen);
      end
      seen++;
    end
    if (!b.last_score) return 1'b0;
    conf = best_s;
    cls = best_c;
    best_s = '0;
    best_c = '0;
    seen = 0;
    if (conf <= thr_q) return 1'b0;
    ok_x = map_axis(held_cx, held_w, pad_x_q, img_w_q, lx, wx);
    ok_y = map_axis(held_cy, held_h, pad_y_q, img_h_q, ty, hy);
    if (!ok_x || !ok_y) return 1'b0;
    d.class_id   = cls;
    d.confidence = conf;
    d.left       = 13'(lx);
    d.top        = 13'(ty);
    d.width      = 14'(wx);
    d.height     = 14'(hy);
    return 1'b1;
  endfunction

  function automatic int draw_wait();
    if (no_idle || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(1, 18);
  endfunction

  // Present one beat after a random gap and hold it until accepted
  task automatic send_beat(input cand_t b);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      cand_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cand_valid <= 1'b1;
    cand <= b;
    do @(posedge clk); while (cand_stall);
  endtask

  task automatic push_beat(input cand_t b);
    det_t d;
    send_beat(b);
    if (decode_beat(b, d)) pending_dets.insert(pending_dets.size(), d);
  endtask

  // Drop valid, wait for every detection, then let the pipeline empty
  task automatic drain();
    @(negedge clk);
    cand_valid <= 1'b0;
    while (pending_dets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_SCORE_THRESHOLD: thr_q   = val[15:0];
      REG_INVERSE_GAIN:    gain_q  = val;
      REG_PAD_X:           pad_x_q = val[14:0];
      REG_PAD_Y:           pad_y_q = val[14:0];
      REG_IMAGE_WIDTH:     img_w_q = val[13:0];
      REG_IMAGE_HEIGHT:    img_h_q = val[13:0];
      REG_CLASS_COUNT:     class_q = val[8:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input cfg_row_t c);
    write_reg(REG_SCORE_THRESHOLD, 24'(c.thr));
    write_reg(REG_INVERSE_GAIN, 24'(c.gain));
    write_reg(REG_PAD_X, 24'(c.padx));
    write_reg(REG_PAD_Y, 24'(c.pady));
    write_reg(REG_IMAGE_WIDTH, 24'(c.iw));
    write_reg(REG_IMAGE_HEIGHT, 24'(c.ih));
    write_reg(REG_CLASS_COUNT, 24'(c.cls));
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic cand_t rand_beat();
    cand_t b;
    b.kind       = 1'($urandom_range(0, 1));
    b.centre_x   = 16'($urandom);
    b.centre_y   = 16'($urandom);
    b.box_width  = 16'($urandom);
    b.box_height = 16'($urandom);
    b.score      = 16'($urandom);
    b.last_score = 1'($urandom_range(0, 1));
    return b;
  endfunction

  // Mostly whole boxes with plausible geometry; some ties and threshold hits
  task automatic run_phase(input int n_beats);
    int          sent, eff, n_scores;
    cand_t       b;
    logic [15:0] prev;
    sent = 0;
    eff = int'(class_q);
    if (eff < 1) eff = 1;
    if (eff > MAX_CLASSES_DEF) eff = MAX_CLASSES_DEF;
    while (sent < n_beats) begin
      b = rand_beat();
      if ($urandom_range(0, 9) < 8) begin
        b.kind = KIND_COORD;
        if ($urandom_range(0, 7) != 0) begin
          b.centre_x   = 16'(pad_x_q + $urandom_range(0, 16 * 1024));
          b.centre_y   = 16'(pad_y_q + $urandom_range(0, 16 * 1024));
          b.box_width  = 16'($urandom_range(1, 16 * 300));
          b.box_height = 16'($urandom_range(1, 16 * 300));
        end
        push_beat(b);
        sent++;
        if ($urandom_range(0, 5) == 0) n_scores = $urandom_range(1, eff + 2);
        else n_scores = $urandom_range(1, eff < 6 ? eff : 6);
        prev = 16'($urandom);
        for (int i = 0; i < n_scores; i++) begin
          b = rand_beat();
          b.kind = KIND_SCORE;
          case ($urandom_range(0, 7))
            0: b.score = prev;
            1: b.score = thr_q;
            default: b.score = 16'($urandom);
          endcase
          prev = b.score;
          b.last_score = (i == n_scores - 1);
          push_beat(b);
          sent++;
        end
      end else begin
        push_beat(b);
        sent++;
      end
    end
  endtask

  // Output side: random stall before each beat
  initial begin
    int n;
    det_stall = 1'b0;
    forever begin
      n = draw_wait();
      @(negedge clk);
      if (n > 0) begin
        det_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      det_stall <= 1'b0;
      do @(posedge clk); while (!det_valid);
    end
  end

  // Compare each accepted detection with the oldest expectation
  always @(posedge clk) begin
    det_t want;
    if (!rst && det_valid && !det_stall) begin
      if (pending_dets.size() == 0) begin
        report_mismatch("detection with none expected");
      end else begin
        want = pending_dets.pop_front();
        if (det.class_id !== want.class_id)
          report_mismatch($sformatf("class_id %0d, want %0d",
                                    det.class_id, want.class_id));
        if (det.confidence !== want.confidence)
          report_mismatch($sformatf("confidence %h, want %h",
                                    det.confidence, want.confidence));
        if (det.left !== want.left)
          report_mismatch($sformatf("left %0d, want %0d", det.left, want.left));
        if (det.top !== want.top)
          report_mismatch($sformatf("top %0d, want %0d", det.top, want.top));
        if (det.width !== want.width)
          report_mismatch($sformatf("width %0d, want %0d", det.width, want.width));
        if (det.height !== want.height)
          report_mismatch($sformatf("height %0d, want %0d", det.height, want.height));
      end
    end
  end

  // Watchdog
  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    cand_t    b;
    det_t     d, typed;
    bit       hit;
    cfg_row_t c;
    rst        = 1'b1;
    cand_valid = 1'b0;
    cand       = '0;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    thr_q   = SCORE_THRESHOLD_RST;
    gain_q  = INVERSE_GAIN_RST;
    pad_x_q = PAD_RST;
    pad_y_q = PAD_RST;
    img_w_q = IMAGE_SIDE_RST;
    img_h_q = IMAGE_SIDE_RST;
    class_q = CLASS_COUNT_RST;
    held_cx = '0;
    held_cy = '0;
    held_w  = '0;
    held_h  = '0;
    best_s  = '0;
    best_c  = '0;
    seen    = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      b = '0;
      b.kind       = dir_tab[i].kind;
      b.centre_x   = 16'(dir_tab[i].cx);
      b.centre_y   = 16'(dir_tab[i].cy);
      b.box_width  = 16'(dir_tab[i].bw);
      b.box_height = 16'(dir_tab[i].bh);
      b.score      = 16'(dir_tab[i].sc);
      b.last_score = dir_tab[i].last;
      send_beat(b);
      hit = decode_beat(b, d);
      typed.class_id   = 8'(dir_tab[i].e_cls);
      typed.confidence = 16'(dir_tab[i].e_conf);
      typed.left       = 13'(dir_tab[i].e_left);
      typed.top        = 13'(dir_tab[i].e_top);
      typed.width      = 14'(dir_tab[i].e_w);
      typed.height     = 14'(dir_tab[i].e_h);
      case (dir_tab[i].chk)
        CHK_DET:   pending_dets.insert(pending_dets.size(), typed);
        CHK_MODEL: if (hit) pending_dets.insert(pending_dets.size(), d);
        default: ;
      endcase
    end
    drain();

    // Random boxes under each register setting
    for (int p = 0; p < PHASES; p++) begin
      if (p < FIXED_CFGS) begin
        c = fixed_cfgs[p];
      end else begin
        c.thr   = $urandom_range(0, 'h9000);
        c.gain  = $urandom_range('h8000, 'h20000);
        c.padx  = $urandom_range(0, 16 * 640);
        c.pady  = $urandom_range(0, 16 * 640);
        c.iw    = $urandom_range(16, 2000);
        c.ih    = $urandom_range(16, 2000);
        c.cls   = $urandom_range(1, 8);
        c.quiet = ($urandom_range(0, 3) == 0);
      end
      apply_config(c);
      no_idle = c.quiet;
      run_phase(PHASE_BEATS);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
